[rtl/wbps_pkg.sv]
package wbps_pkg;

  localparam int PATTERN_MAX_DEF = 32;
  localparam int OFFSET_BITS_DEF = 32;

  localparam int CFG_W         = 64;
  localparam int CFG_IDX_W     = 3;
  localparam int NUM_PAT_WORDS = 4;
  localparam int PAT_WORD_IDX_W = 2;
  localparam int LEN_REG_W     = 6;
  localparam int OUT_OFFSET_W  = 32;

  localparam logic [7:0] WILDCARD_BYTE = 8'h2A;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN   = 3'd4;

  localparam logic [LEN_REG_W-1:0] PATTERN_LEN_RESET = 6'd1;

  typedef logic [7:0] byte_t;
  typedef logic [CFG_W-1:0] pat_word_t;

endpackage

[rtl/wildcard_byte_pattern_scan_core.sv]
// Wildcard byte pattern scan.
// A memory region streams in one byte per input transaction (data_byte), with
// last_byte set on the final byte. The newest pattern_len bytes are compared
// against the configured pattern; a pattern byte of 0x2A matches any byte.
// The first hit in a region yields one output transaction with found = 1 and
// match_offset = offset of the match start; the rest of the region is dropped.
// A region with no hit yields found = 0, match_offset = 0 on its last byte.
// Configuration: cfg_wr_en/cfg_index/cfg_data write pattern words 0..3
// (index 0..3) and pattern_len (index 4); write only while the block is idle.
// Each byte passes from the input register through the compare stage into
// the output register. Throughput: one byte per cycle while in_stall is low;
// in_stall rises only while a byte is held in the input register and the
// output register is full and out_stall is high.
// Reset (rst, synchronous): pattern words clear to 0, pattern_len to 1, the
// scan state and both pipeline registers go empty.
module wildcard_byte_pattern_scan_core #(
  parameter int PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEF,
  parameter int OFFSET_BITS = wbps_pkg::OFFSET_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wr_en,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [wbps_pkg::CFG_W-1:0]            cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [7:0]                            data_byte,
  input  logic                                  last_byte,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  found,
  output logic [wbps_pkg::OUT_OFFSET_W-1:0]     match_offset
);
  import wbps_pkg::*;

  localparam int LEN_W = $clog2(PATTERN_MAX + 1);
  localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  pat_word_t              pat_words [NUM_PAT_WORDS];
  logic [LEN_REG_W-1:0]   pattern_len;

  logic                   s1_valid;
  byte_t                  s1_byte;
  logic                   s1_last;

  byte_t                  byte_window [PATTERN_MAX];
  byte_t                  window_next [PATTERN_MAX];
  logic [OFFSET_BITS-1:0] byte_count;
  logic [OFFSET_BITS-1:0] count_next;
  logic [OFFSET_BITS-1:0] start_offset;
  logic                   match_reported;

  logic [LEN_W-1:0]       used_len;
  logic                   window_hit;
  logic                   hit;
  logic                   emit;
  logic                   out_free;
  logic                   s1_go;
  logic                   in_accept;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < NUM_PAT_WORDS; w++) begin
        pat_words[w] <= '0;
      end
      pattern_len <= PATTERN_LEN_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_PATTERN_WORD0,
        REG_PATTERN_WORD1,
        REG_PATTERN_WORD2,
        REG_PATTERN_WORD3: pat_words[cfg_index[PAT_WORD_IDX_W-1:0]] <= cfg_data;
        REG_PATTERN_LEN:   pattern_len <= cfg_data[LEN_REG_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_free  = !out_valid || !out_stall;
  assign s1_go     = s1_valid && out_free;
  assign in_stall  = s1_valid && !out_free;
  assign in_accept = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte <= data_byte;
      s1_last <= last_byte;
    end
  end

  // Compare stage
  always_comb begin
    if (pattern_len == '0) begin
      used_len = LEN_W'(1);
    end else if (pattern_len > LEN_REG_W'(PATTERN_MAX)) begin
      used_len = LEN_W'(PATTERN_MAX);
    end else begin
      used_len = LEN_W'(pattern_len);
    end
  end

  always_comb begin
    window_next[0] = s1_byte;
    for (int k = 1; k < PATTERN_MAX; k++) begin
      window_next[k] = byte_window[k-1];
    end
  end

  assign count_next   = (byte_count == '1) ? byte_count : byte_count + OFFSET_BITS'(1);
  assign start_offset = count_next - OFFSET_BITS'(used_len);

  always_comb begin
    logic [LEN_W-1:0] idx;
    byte_t            pbyte;
    logic             in_use;
    window_hit = 1'b1;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      pbyte  = pat_words[i >> 3][(i & 7) * 8 +: 8];
      in_use = LEN_W'(i) < used_len;
      idx    = used_len - LEN_W'(1) - LEN_W'(i);
      if (in_use && pbyte != WILDCARD_BYTE &&
          pbyte != window_next[idx[IDX_W-1:0]]) begin
        window_hit = 1'b0;
      end
    end
  end

  assign hit  = !match_reported && (count_next >= OFFSET_BITS'(used_len)) && window_hit;
  assign emit = hit || (s1_last && !match_reported);

  // Scan state
  always_ff @(posedge clk) begin
    if (s1_go && !match_reported) begin
      for (int k = 0; k < PATTERN_MAX; k++) begin
        byte_window[k] <= window_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      match_reported <= 1'b0;
    end else if (s1_go) begin
      if (s1_last) begin
        byte_count     <= '0;
        match_reported <= 1'b0;
      end else if (!match_reported) begin
        byte_count     <= count_next;
        match_reported <= hit;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && emit) begin
      found        <= hit;
      match_offset <= hit ? OUT_OFFSET_W'(start_offset) : '0;
    end
  end

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (match_offset == '0))
    else $error("not-found result with nonzero offset");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_last) |=> (byte_count == '0 && !match_reported))
    else $error("scan state not cleared after last byte");

  a_hit_reported: assert property (@(posedge clk) disable iff (rst)
    $rose(match_reported) |-> (out_valid && found))
    else $error("match recorded without a found result");

  a_stall_when_full: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && out_stall) |-> in_stall)
    else $error("input not stalled while pipeline is blocked");

endmodule
